/* design/itdc_pkg.sv */
// Shared types and constants for the integer-to-decimal text formatter.
`default_nettype none
package itdc_pkg;

   localparam int VALUE_BITS  = 64;
   localparam int DIGIT_BITS  = 4;
   localparam int CHAR_BITS   = 8;
   localparam int GROUP_SIZE  = 3;

   localparam logic [CHAR_BITS-1:0]  CH_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0]  CH_COMMA = 8'h2C;
   localparam logic [CHAR_BITS-1:0]  CH_MINUS = 8'h2D;

   // shift-and-add-3 correction for one decimal digit
   localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_BITS-1:0] DABBLE_ADD   = 4'd3;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic shift;
   } cell_ctl_type;

endpackage
`default_nettype wire

/* design/int_to_decimal_with_commas.sv */
// Top level: signed integer to comma-grouped decimal ASCII, one character per transfer.
//
// Each accepted value is converted by a chain of BCD digit cells, one input bit per
// cycle. Leading zeros are then shifted out of the top cell, one per cycle (the chain
// has NDIG = 19 cells at width 64), and the text leaves one character per cycle while
// rsp_stall does not hold a full output register: optional '-', digits with ','
// between groups of three, last character flagged. The conversion chain holds one item
// at a time, so req_stall is high from acceptance until the last character has been
// moved into the output register.
`default_nettype none
module int_to_decimal_with_commas #(
   parameter int VALUE_WIDTH = 64
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  signed [itdc_pkg::VALUE_BITS-1:0] req_value,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [itdc_pkg::CHAR_BITS-1:0]      rsp_character,
   output logic                                rsp_last_char
);

   localparam int NDIG  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
   localparam int REM_W = $clog2(NDIG + 1);
   localparam int CNT_W = $clog2(VALUE_WIDTH);

   typedef enum logic [2:0] {
      IDLE,
      CONV,
      SKIP,
      SIGN,
      DIGIT,
      COMMA
   } state_type;

   state_type                        state_ff, state_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0]           mag_ff, mag_in;
   logic                             neg_ff, neg_in;
   logic [REM_W-1:0]                 rem_ff, rem_in;
   logic [1:0]                       grp_ff, grp_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [itdc_pkg::CHAR_BITS-1:0]   rsp_character_ff, rsp_character_in;
   logic                             rsp_last_char_ff, rsp_last_char_in;

   itdc_pkg::cell_ctl_type           ctl;
   logic [NDIG:0]                    carry;
   logic [itdc_pkg::DIGIT_BITS-1:0]  digit [NDIG];
   logic [VALUE_WIDTH-1:0]           bits;
   logic [itdc_pkg::DIGIT_BITS-1:0]  top_digit;
   logic [1:0]                       grp_dec;
   logic                             out_free;

   assign carry[0] = mag_ff[VALUE_WIDTH-1];

   for (genvar i = 0; i < NDIG; i++) begin : g_cell
      logic [itdc_pkg::DIGIT_BITS-1:0] lo_digit;
      if (i == 0) begin : g_first
         assign lo_digit = '0;
      end else begin : g_rest
         assign lo_digit = digit[i-1];
      end
      itdc_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .lo_carry (carry[i]),
         .lo_digit (lo_digit),
         .hi_carry (carry[i+1]),
         .digit    (digit[i])
      );
   end

   assign bits      = req_value[VALUE_WIDTH-1:0];
   assign top_digit = digit[NDIG-1];
   assign grp_dec   = (grp_ff == 2'd0) ? 2'(itdc_pkg::GROUP_SIZE - 1) : grp_ff - 2'd1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      mag_in           = mag_ff;
      neg_in           = neg_ff;
      rem_in           = rem_ff;
      grp_in           = grp_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_character_in = rsp_character_ff;
      rsp_last_char_in = rsp_last_char_ff;
      ctl              = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               ctl.clear = 1'b1;
               neg_in    = bits[VALUE_WIDTH-1];
               mag_in    = bits[VALUE_WIDTH-1] ? (~bits + VALUE_WIDTH'(1)) : bits;
               cnt_in    = CNT_W'(VALUE_WIDTH - 1);
               rem_in    = REM_W'(NDIG);
               grp_in    = 2'(NDIG % itdc_pkg::GROUP_SIZE);
               state_in  = CONV;
            end
         end
         CONV: begin
            ctl.dabble = 1'b1;
            mag_in     = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            if (cnt_ff == '0) begin
               state_in = SKIP;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         SKIP: begin
            if (top_digit == '0 && rem_ff > REM_W'(1)) begin
               ctl.shift = 1'b1;
               rem_in    = rem_ff - REM_W'(1);
               grp_in    = grp_dec;
            end else begin
               state_in = neg_ff ? SIGN : DIGIT;
            end
         end
         SIGN: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = itdc_pkg::CH_MINUS;
               rsp_last_char_in = 1'b0;
               state_in         = DIGIT;
            end
         end
         DIGIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = itdc_pkg::CH_ZERO + {4'b0000, top_digit};
               rsp_last_char_in = (rem_ff == REM_W'(1));
               ctl.shift        = 1'b1;
               rem_in           = rem_ff - REM_W'(1);
               grp_in           = grp_dec;
               if (rem_ff == REM_W'(1)) begin
                  state_in = IDLE;
               end else if (grp_dec == 2'd0) begin
                  state_in = COMMA;
               end
            end
         end
         COMMA: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = itdc_pkg::CH_COMMA;
               rsp_last_char_in = 1'b0;
               state_in         = DIGIT;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff           <= cnt_in;
      mag_ff           <= mag_in;
      neg_ff           <= neg_in;
      rem_ff           <= rem_in;
      grp_ff           <= grp_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_char_ff <= rsp_last_char_in;
   end

   assign req_stall     = (state_ff != IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last_char = rsp_last_char_ff;

   // magnitude always fits the digit chain
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CONV) |-> !carry[NDIG])
      else $error("digit chain overflow");

   // the flagged final character is a digit
   a_last_is_digit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_char) |->
         (rsp_character >= itdc_pkg::CH_ZERO &&
          rsp_character <= itdc_pkg::CH_ZERO + 8'd9))
      else $error("last character is not a digit");

   // a comma always follows a digit
   a_comma_after_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == COMMA) |-> (rem_ff != '0 && grp_ff == 2'd0))
      else $error("comma placed outside a group boundary");

   // an accepted item blocks further input and starts its conversion
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (req_stall && state_ff == CONV))
      else $error("input accepted while converting");

endmodule
`default_nettype wire

/* design/itdc_cell.sv */
// One BCD digit cell of the binary-to-decimal conversion chain.
`default_nettype none
module itdc_cell (
   input  wire                                clock,
   input  wire  itdc_pkg::cell_ctl_type       ctl,
   input  wire                                lo_carry,
   input  wire  [itdc_pkg::DIGIT_BITS-1:0]    lo_digit,
   output logic                               hi_carry,
   output logic [itdc_pkg::DIGIT_BITS-1:0]    digit
);

   logic [itdc_pkg::DIGIT_BITS-1:0] digit_ff;
   logic [itdc_pkg::DIGIT_BITS-1:0] digit_in;
   logic [itdc_pkg::DIGIT_BITS-1:0] adj;

   always_comb begin
      adj = (digit_ff >= itdc_pkg::DABBLE_LIMIT) ? digit_ff + itdc_pkg::DABBLE_ADD : digit_ff;
      hi_carry = adj[itdc_pkg::DIGIT_BITS-1];
      digit_in = digit_ff;
      if (ctl.clear) begin
         digit_in = '0;
      end else if (ctl.dabble) begin
         digit_in = {adj[itdc_pkg::DIGIT_BITS-2:0], lo_carry};
      end else if (ctl.shift) begin
         digit_in = lo_digit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule
`default_nettype wire

/* tb/int_to_decimal_with_commas_tb.sv */
// Testbench for int_to_decimal_with_commas: directed and random values checked per character.
`timescale 1ns / 1ps
module int_to_decimal_with_commas_tb;

   localparam int VALUE_WIDTH = 64;
   localparam int RANDOM_ITEMS = 186;
   localparam int DIR_N = 24;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_CYCLES = 120;
   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic [itdc_pkg::CHAR_BITS-1:0] character;
      logic                           last_char;
   } text_char_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic signed [itdc_pkg::VALUE_BITS-1:0] req_value = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic [itdc_pkg::CHAR_BITS-1:0]         rsp_character;
   logic                                   rsp_last_char;

   text_char_type expected_text_q[$];
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            value_count = 0;
   int            negative_count = 0;
   int            char_count = 0;
   int            stall_left = 0;
   bit            calm = 1'b0;

   // directed values; an empty string means the predictor supplies the text
   logic [63:0] dir_value [DIR_N] = '{
      64'd0, 64'd1, -64'd1, 64'd9, 64'd10, 64'd100, 64'd999, 64'd1000,
      -64'd1000, 64'd12345, 64'd123456, 64'd1234567, -64'd999999, 64'd1000000,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
      64'hFFFF_FFFF_FFFF_FFFE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
      64'd999999999999999999, 64'd1000000000000000000, -64'd1000000000000000000,
      64'd4294967296
   };
   string dir_text [DIR_N] = '{
      "0", "1", "-1", "", "", "100", "999", "1,000",
      "-1,000", "", "", "", "", "1,000,000",
      "9,223,372,036,854,775,807", "-9,223,372,036,854,775,808", "",
      "-2", "", "",
      "", "1,000,000,000,000,000,000", "",
      ""
   };

   int_to_decimal_with_commas #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_character(rsp_character),
      .rsp_last_char(rsp_last_char)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // decimal text with comma grouping, built from the least significant digit
   function automatic void predict_text(logic [63:0] raw);
      logic [63:0]                    mask;
      logic [63:0]                    bits;
      logic [63:0]                    mag;
      logic                           neg;
      logic [3:0]                     digit;
      logic [itdc_pkg::CHAR_BITS-1:0] rev [32];
      int                             n;
      int                             in_group;
      text_char_type                  tc;
      mask = ~64'd0 >> (64 - VALUE_WIDTH);
      bits = raw & mask;
      neg = bits[VALUE_WIDTH-1];
      mag = neg ? ((~bits + 64'd1) & mask) : bits;
      n = 0;
      in_group = 0;
      do begin
         digit = 4'(mag % 64'd10);
         mag = mag / 64'd10;
         if (in_group == itdc_pkg::GROUP_SIZE) begin
            rev[n] = itdc_pkg::CH_COMMA;
            n++;
            in_group = 0;
         end
         rev[n] = itdc_pkg::CH_ZERO + itdc_pkg::CHAR_BITS'(digit);
         n++;
         in_group++;
      end while (mag != 0 && n < 30);
      if (neg) begin
         rev[n] = itdc_pkg::CH_MINUS;
         n++;
      end
      for (int k = 0; k < n; k++) begin
         tc.character = rev[n - 1 - k];
         tc.last_char = (k == n - 1);
         expected_text_q.push_back(tc);
      end
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED)
         $display("ERROR cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic send_value(input logic [63:0] v, input string text);
      int            gap;
      text_char_type tc;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_value <= {$urandom, $urandom};
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_stall);
      value_count++;
      if (v[VALUE_WIDTH-1]) negative_count++;
      if (text.len() == 0) begin
         predict_text(v);
      end else begin
         for (int i = 0; i < text.len(); i++) begin
            tc.character = text[i];
            tc.last_char = (i == text.len() - 1);
            expected_text_q.push_back(tc);
         end
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters outstanding",
                  cycle_count, expected_text_q.size());
         $display("FAIL int_to_decimal_with_commas");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = idle_cycles();
      end
   end

   always @(posedge clock) begin
      text_char_type exp_c;
      if (!reset && rsp_valid && !rsp_stall) begin
         char_count++;
         if (expected_text_q.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                      rsp_character, rsp_last_char));
         end else begin
            exp_c = expected_text_q.pop_front();
            if (rsp_character !== exp_c.character)
               report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                         rsp_character, exp_c.character));
            if (rsp_last_char !== exp_c.last_char)
               report_mismatch($sformatf("last_char %0b, expected %0b",
                                         rsp_last_char, exp_c.last_char));
         end
      end
   end

   initial begin
      logic [63:0] v;
      logic [63:0] pow10;
      int          kind;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_N; i++)
         send_value(dir_value[i], dir_text[i]);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 19) == 0) calm = !calm;
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            v = {$urandom, $urandom};
         end else if (kind < 6) begin
            v = 64'($urandom_range(0, 2000));
            if ($urandom_range(0, 1)) v = -v;
         end else if (kind < 8) begin
            // digit-count and group boundaries
            pow10 = 64'd1;
            repeat ($urandom_range(0, 18)) pow10 = pow10 * 64'd10;
            v = pow10 + 64'($urandom_range(0, 2)) - 64'd1;
            if ($urandom_range(0, 1)) v = -v;
         end else begin
            v = {$urandom, $urandom} >> $urandom_range(0, 63);
            if ($urandom_range(0, 1)) v = -v;
         end
         send_value(v, "");
      end

      req_valid <= 1'b0;
      calm = 1'b0;
      while (expected_text_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Formatted %0d values (%0d negative) into %0d characters,",
               value_count, negative_count, char_count);
      $display("with zero, both extremes and group boundaries under random stalls.");
      if (mismatch_count == 0) begin
         $display("PASS int_to_decimal_with_commas");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAIL int_to_decimal_with_commas");
      end
      $finish;
   end

endmodule
